/* sv/cau_pkg.sv */
// Shared codes and default widths for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

endpackage

/* sv/complex_arithmetic_unit_top.sv */
// Complex arithmetic unit: pipelined add, subtract, multiply, divide and compare in fixed point.
`timescale 1ns / 1ps
//
// Usage
//   Input channel s_*: one transaction carries an operation code (s_tuser) and two
//   complex operands a and b (s_tdata), each part signed with FRAC_BITS fraction bits.
//   Output channel m_*: one transaction per input transaction, in input order, with
//   the saturated real and imaginary result, the equality flag and a status code
//   (ok, saturated, divide by zero).
//   Pipeline: every operation takes the same path. Four front stages handle operand
//   capture, the 6 partial multiplies, the cross sums and sign/magnitude; the quotient
//   takes one restoring-divide stage per result bit, then the output register holds
//   the saturated result.
//   Throughput: one transaction per cycle while the output is not stalled, set by the
//   fully pipelined divider.
//   Reset (rst, synchronous): all stage valid bits clear, the output goes idle;
//   payload registers are not cleared.
//   Stall: when m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops in the same cycle; nothing is lost or repeated.
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_real, a_imag, b_real, b_imag (lowest bits first), zero padded to bytes
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [2:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // result_real, result_imag, equal_flag, status (lowest bits first), zero padded
  output logic [((2*DATA_WIDTH+3+7)/8)*8-1:0] m_tdata
);
  import cau_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 2 * DW;           // product / magnitude width
  localparam int RW  = PW + 1;           // divider partial remainder
  localparam int XW  = PW + FRAC_BITS;   // scaled numerator
  localparam int OTW = ((2*DW+3+7)/8)*8;
  localparam logic [PW-1:0] POS_LIM = (PW'(1) << (DW-1)) - PW'(1);
  localparam logic [PW-1:0] NEG_LIM = PW'(1) << (DW-1);
  localparam logic [PW-1:0] DIV_OVF = PW'(1) << DW;

  typedef struct packed {
    logic          is_div;
    logic          neg_re;
    logic          neg_im;
    logic          qo_re;   // quotient beyond range
    logic          qo_im;
    logic          dz;      // divisor zero
    logic [DW-1:0] rr;
    logic [DW-1:0] ri;
    logic          eq;
    logic [1:0]    st;
  } pass_t;

  // {overflow, clamped value}
  function automatic logic [DW:0] sat(input logic neg, input logic [PW-1:0] mag);
    logic [DW:0]   r;
    logic [DW-1:0] m;
    m = mag[DW-1:0];
    if (!neg) begin
      if (mag > POS_LIM) r = {1'b1, POS_LIM[DW-1:0]};
      else r = {1'b0, m};
    end else begin
      if (mag > NEG_LIM) r = {1'b1, NEG_LIM[DW-1:0]};
      else r = {1'b0, ~m + DW'(1)};
    end
    return r;
  endfunction

  logic en;
  logic out_v;
  assign en       = !out_v || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_v;

  // stage 1: capture
  logic                 v1;
  logic [2:0]           k1;
  logic signed [DW-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      k1  <= s_tuser;
      ar1 <= s_tdata[DW-1:0];
      ai1 <= s_tdata[2*DW-1:DW];
      br1 <= s_tdata[3*DW-1:2*DW];
      bi1 <= s_tdata[4*DW-1:3*DW];
    end
  end

  // stage 2: products, short sums, compare
  logic                 v2;
  logic [2:0]           k2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;
  logic signed [DW:0]   sa_r, sa_i;
  logic                 eq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      k2    <= k1;
      p_rr  <= PW'(ar1) * PW'(br1);
      p_ii  <= PW'(ai1) * PW'(bi1);
      p_ri  <= PW'(ar1) * PW'(bi1);
      p_ir  <= PW'(ai1) * PW'(br1);
      p_br2 <= PW'(br1) * PW'(br1);
      p_bi2 <= PW'(bi1) * PW'(bi1);
      if (k1 == KIND_SUB) begin
        sa_r <= (DW+1)'(ar1) - (DW+1)'(br1);
        sa_i <= (DW+1)'(ai1) - (DW+1)'(bi1);
      end else begin
        sa_r <= (DW+1)'(ar1) + (DW+1)'(br1);
        sa_i <= (DW+1)'(ai1) + (DW+1)'(bi1);
      end
      eq2 <= (ar1 == br1) && (ai1 == bi1);
    end
  end

  // stage 3: cross sums, divisor, add/sub saturation
  logic                 v3;
  logic [2:0]           k3;
  logic signed [PW:0]   sr3, si3;
  logic [PW-1:0]        den3;
  logic [DW-1:0]        rr3, ri3;
  logic                 ovf3, eq3;
  logic [DW:0]          as_r, as_i;

  always_comb begin
    as_r = sat(sa_r[DW], PW'(sa_r[DW] ? -sa_r : sa_r));
    as_i = sat(sa_i[DW], PW'(sa_i[DW] ? -sa_i : sa_i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      k3   <= k2;
      den3 <= PW'(p_br2) + PW'(p_bi2);
      if (k2 == KIND_MUL) begin
        sr3 <= (PW+1)'(p_rr) - (PW+1)'(p_ii);
        si3 <= (PW+1)'(p_ri) + (PW+1)'(p_ir);
      end else begin
        sr3 <= (PW+1)'(p_rr) + (PW+1)'(p_ii);
        si3 <= (PW+1)'(p_ir) - (PW+1)'(p_ri);
      end
      rr3  <= as_r[DW-1:0];
      ri3  <= as_i[DW-1:0];
      ovf3 <= as_r[DW] || as_i[DW];
      eq3  <= (k2 == KIND_CMP) && eq2;
    end
  end

  // stage 4: sign/magnitude, multiply saturation, divider setup
  logic          d_v   [0:DW];
  pass_t         d_p   [0:DW];
  logic [RW-1:0] d_rre [0:DW];
  logic [RW-1:0] d_rim [0:DW];
  logic [DW-1:0] d_xre [0:DW];
  logic [DW-1:0] d_xim [0:DW];
  logic [DW-1:0] d_qre [0:DW];
  logic [DW-1:0] d_qim [0:DW];
  logic [PW-1:0] d_den [0:DW];

  logic [PW:0]   mag_re_w, mag_im_w;
  logic [PW-1:0] mag_re, mag_im;
  logic          neg_re, neg_im;
  logic [DW:0]   ms_r, ms_i;
  logic [XW-1:0] x_re, x_im;
  logic [XW-1:0] xh_re, xh_im;
  pass_t         p4;

  always_comb begin
    neg_re   = sr3[PW];
    neg_im   = si3[PW];
    mag_re_w = neg_re ? -sr3 : sr3;
    mag_im_w = neg_im ? -si3 : si3;
    mag_re   = mag_re_w[PW-1:0];
    mag_im   = mag_im_w[PW-1:0];
    ms_r     = sat(neg_re, mag_re >> FRAC_BITS);
    ms_i     = sat(neg_im, mag_im >> FRAC_BITS);
    x_re     = XW'(mag_re) << FRAC_BITS;
    x_im     = XW'(mag_im) << FRAC_BITS;
    xh_re    = x_re >> DW;
    xh_im    = x_im >> DW;

    p4        = '0;
    p4.is_div = (k3 == KIND_DIV);
    p4.neg_re = neg_re;
    p4.neg_im = neg_im;
    p4.qo_re  = xh_re >= XW'(den3);
    p4.qo_im  = xh_im >= XW'(den3);
    p4.dz     = (den3 == '0);
    p4.eq     = eq3;
    case (k3) inside
      KIND_ADD, KIND_SUB: begin
        p4.rr = rr3;
        p4.ri = ri3;
        p4.st = ovf3 ? ST_SAT : ST_OK;
      end
      KIND_MUL: begin
        p4.rr = ms_r[DW-1:0];
        p4.ri = ms_i[DW-1:0];
        p4.st = (ms_r[DW] || ms_i[DW]) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= v3;
    end
    if (en) begin
      d_p[0]   <= p4;
      d_rre[0] <= RW'(xh_re);
      d_rim[0] <= RW'(xh_im);
      d_xre[0] <= x_re[DW-1:0];
      d_xim[0] <= x_im[DW-1:0];
      d_qre[0] <= '0;
      d_qim[0] <= '0;
      d_den[0] <= den3;
    end
  end

  // restoring divider, one quotient bit per stage for both parts
  for (genvar g = 0; g < DW; g++) begin : g_div
    logic [RW-1:0] rs_re, rs_im;
    logic          ge_re, ge_im;

    assign rs_re = {d_rre[g][RW-2:0], d_xre[g][DW-1]};
    assign rs_im = {d_rim[g][RW-2:0], d_xim[g][DW-1]};
    assign ge_re = rs_re >= RW'(d_den[g]);
    assign ge_im = rs_im >= RW'(d_den[g]);

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[g+1] <= 1'b0;
      end else if (en) begin
        d_v[g+1] <= d_v[g];
      end
      if (en) begin
        d_p[g+1]   <= d_p[g];
        d_den[g+1] <= d_den[g];
        d_rre[g+1] <= ge_re ? rs_re - RW'(d_den[g]) : rs_re;
        d_rim[g+1] <= ge_im ? rs_im - RW'(d_den[g]) : rs_im;
        d_xre[g+1] <= d_xre[g] << 1;
        d_xim[g+1] <= d_xim[g] << 1;
        d_qre[g+1] <= {d_qre[g][DW-2:0], ge_re};
        d_qim[g+1] <= {d_qim[g][DW-2:0], ge_im};
      end
    end
  end

  // final saturation and output register
  pass_t          pf;
  logic [DW:0]    qs_r, qs_i;
  logic [OTW-1:0] out_next;

  always_comb begin
    pf   = d_p[DW];
    qs_r = sat(pf.neg_re, pf.qo_re ? DIV_OVF : PW'(d_qre[DW]));
    qs_i = sat(pf.neg_im, pf.qo_im ? DIV_OVF : PW'(d_qim[DW]));
  end

  always_comb begin
    out_next = '0;
    if (pf.is_div) begin
      if (pf.dz) begin
        out_next[2*DW+2:2*DW+1] = ST_DIV0;
      end else begin
        out_next[DW-1:0]        = qs_r[DW-1:0];
        out_next[2*DW-1:DW]     = qs_i[DW-1:0];
        out_next[2*DW+2:2*DW+1] = (qs_r[DW] || qs_i[DW]) ? ST_SAT : ST_OK;
      end
    end else begin
      out_next[DW-1:0]        = pf.rr;
      out_next[2*DW-1:DW]     = pf.ri;
      out_next[2*DW]          = pf.eq;
      out_next[2*DW+2:2*DW+1] = pf.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= d_v[DW];
    end
    if (en) begin
      m_tdata <= out_next;
    end
  end

endmodule

/* sv/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module cau_checker #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  input logic [2:0] s_tuser,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*DATA_WIDTH+3+7)/8)*8-1:0] m_tdata
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [1:0] st;
  logic       eq;
  assign st = m_tdata[2*DW+2:2*DW+1];
  assign eq = m_tdata[2*DW];

  // stalled output transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input changed while stalled");

  // input side is open whenever output is free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input blocked without output stall");

  // equality result carries zero data and ok status
  a_eq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && eq |-> st == ST_OK && m_tdata[2*DW-1:0] == '0)
    else $error("compare result with data or status");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the complex arithmetic unit: directed and random operand streams.
`timescale 1ns / 1ps
module tb_top;
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int SDW = ((4*DW+7)/8)*8;
  localparam int MDW = ((2*DW+3+7)/8)*8;
  localparam int LATENCY = DW + 5;
  localparam int N_RANDOM = 1700;

  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [31:0] a_re, a_im, b_re, b_im;
  } op_t;

  typedef struct packed {
    logic signed [31:0] re, im;
    logic eq;
    logic [1:0] st;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SDW-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MDW-1:0] m_tdata;

  complex_arithmetic_unit_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  op_t op_queue[$];          // operations waiting to be driven
  res_t expected_results[$]; // predicted results, oldest first
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_sender = 1'b0;    // pauses the driver until all results drain
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;       // input transaction taken at the last rising edge
  int mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturate a signed magnitude to 32 bits; sets ovf when clamped.
  function automatic logic signed [31:0] sat_sm(input bit neg, input logic [127:0] mag,
                                                inout bit ovf);
    if (!neg) begin
      if (mag > 128'h7fffffff) begin
        ovf = 1'b1;
        return QMAX;
      end
      return mag[31:0];
    end
    if (mag > 128'h80000000) begin
      ovf = 1'b1;
      return QMIN;
    end
    return 32'(-$signed({1'b0, mag[31:0]}));
  endfunction

  function automatic logic [127:0] mag_of(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Exact complex arithmetic in wide signed math, truncation toward zero.
  function automatic res_t complex_result(input op_t op);
    res_t r;
    bit ovf;
    logic signed [127:0] ar, ai, br, bi, x, y, den;
    ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
    r = '0;
    ovf = 1'b0;
    case (op.kind) inside
      KIND_ADD, KIND_SUB: begin
        x = (op.kind == KIND_ADD) ? ar + br : ar - br;
        y = (op.kind == KIND_ADD) ? ai + bi : ai - bi;
        r.re = sat_sm(x < 0, mag_of(x), ovf);
        r.im = sat_sm(y < 0, mag_of(y), ovf);
      end
      KIND_MUL: begin
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        r.re = sat_sm(x < 0, mag_of(x) >> FB, ovf);
        r.im = sat_sm(y < 0, mag_of(y) >> FB, ovf);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DIV0;
        end else begin
          x = ar * br + ai * bi;
          y = ai * br - ar * bi;
          r.re = sat_sm(x < 0, (mag_of(x) << FB) / den, ovf);
          r.im = sat_sm(y < 0, (mag_of(y) << FB) / den, ovf);
        end
      end
      KIND_CMP: r.eq = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      default: ;
    endcase
    if (ovf) r.st = ST_SAT;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000; // about +-2.0
      4: return $signed($urandom_range(0, 32'h1ff)) - 32'sh100;     // tiny values
      default: return $urandom();
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t op;
    op.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(KIND_ADD, KIND_CMP));
    op.a_re = rand_part(); op.a_im = rand_part();
    op.b_re = rand_part(); op.b_im = rand_part();
    if (op.kind == KIND_CMP && $urandom_range(0, 1)) begin
      op.b_re = op.a_re;
      if ($urandom_range(0, 2) != 0) op.b_im = op.a_im;
    end
    if (op.kind == KIND_DIV && $urandom_range(0, 9) == 0) begin
      op.b_re = 0; op.b_im = 0;
    end
    return op;
  endfunction

  function automatic op_t mk(input logic [2:0] k, input logic signed [31:0] a, b, c, d);
    op_t op;
    op.kind = k; op.a_re = a; op.a_im = b; op.b_re = c; op.b_im = d;
    return op;
  endfunction

  // Input transactions count at the rising edge; predict each one as it is taken.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(complex_result({s_tuser, s_tdata[DW-1:0],
                                                 s_tdata[2*DW-1:DW], s_tdata[3*DW-1:2*DW],
                                                 s_tdata[4*DW-1:3*DW]}));
    end
  end

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (op_queue.size() > 0 && !hold_sender
            && $urandom_range(0, 99) >= send_idle_pct) begin
          op_t op;
          op = op_queue.pop_front();
          s_tuser <= op.kind;
          s_tdata <= {op.b_im, op.b_re, op.a_im, op.a_re};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      res_t got, exp_r;
      got = {m_tdata[DW-1:0], m_tdata[2*DW-1:DW], m_tdata[2*DW], m_tdata[2*DW+2:2*DW+1]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp re=%h im=%h eq=%b st=%0d got re=%h im=%h eq=%b st=%0d",
                     exp_r.re, exp_r.im, exp_r.eq, exp_r.st,
                     got.re, got.im, got.eq, got.st);
        end
      end
    end
  end

  task automatic wait_drained();
    while (op_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    op_t op;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: extremes, every operation, zero divisor, saturation, unused codes.
    op_queue.push_back(mk(KIND_ADD, QMAX, QMIN, 32'sd1, -32'sd1));
    op_queue.push_back(mk(KIND_ADD, QMIN, QMAX, QMIN, QMAX));
    op_queue.push_back(mk(KIND_SUB, QMIN, QMAX, 32'sd1, -32'sd1));
    op_queue.push_back(mk(KIND_SUB, 32'sh10000, 32'sh20000, 32'sh8000, -32'sh8000));
    op_queue.push_back(mk(KIND_MUL, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000));
    op_queue.push_back(mk(KIND_MUL, QMAX, QMAX, QMAX, QMIN));
    op_queue.push_back(mk(KIND_MUL, QMIN, QMIN, QMIN, QMIN));
    op_queue.push_back(mk(KIND_MUL, -32'sd3, 32'sd5, 32'sd7, -32'sd2));
    op_queue.push_back(mk(KIND_DIV, 32'sh10000, 32'sh20000, 32'sd0, 32'sd0));
    op_queue.push_back(mk(KIND_DIV, 32'sh30000, -32'sh10000, 32'sh10000, 32'sh10000));
    op_queue.push_back(mk(KIND_DIV, QMAX, QMIN, 32'sd1, 32'sd0));
    op_queue.push_back(mk(KIND_DIV, QMIN, QMIN, QMIN, QMIN));
    op_queue.push_back(mk(KIND_DIV, -32'sd1, 32'sd1, QMAX, QMAX));
    op_queue.push_back(mk(KIND_CMP, QMAX, QMIN, QMAX, QMIN));
    op_queue.push_back(mk(KIND_CMP, QMAX, QMIN, QMAX, QMAX));
    op_queue.push_back(mk(KIND_CMP, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    op_queue.push_back(mk(3'd5, QMAX, QMIN, -32'sd1, 32'sd1));
    op_queue.push_back(mk(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1));

    // Random phases with different back-pressure mixes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 35 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        op = rand_op();
        op_queue.push_back(op);
      end
      if (phase == 1) begin
        // Let the sender stop until the pipeline has fully drained, then resume.
        while (op_queue.size() > 200) @(posedge clk);
        hold_sender = 1'b1;
        while (s_tvalid || expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1'b1;
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    if (!stim_done) $display("tb_top: FAIL");
    $finish;
  end

endmodule
